// ----- rtl/sas_pkg.sv -----
// Shared types and constants of the sprite animation sequencer.
package sas_pkg;

	localparam int ACT_BITS     = 2;
	localparam int FRAME_BITS   = 8;
	localparam int ACC_BITS     = 24;
	localparam int ELAPSED_BITS = 16;
	localparam int NUM_SLOTS    = 4;
	localparam int CFG_BITS     = 64;
	localparam int CNT_REG_BITS = NUM_SLOTS * FRAME_BITS;

	localparam logic [ACC_BITS-1:0]   ACC_MAX   = {ACC_BITS{1'b1}};
	localparam logic [FRAME_BITS-1:0] FRAME_MAX = {FRAME_BITS{1'b1}};

	typedef enum logic [1:0] {
		REG_DURATIONS    = 2'd0,
		REG_FRAME_COUNTS = 2'd1,
		REG_LOOPING_MASK = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SET  = 1'b1
	} opcode_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic apply;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_needed;
		logic div_done;
	} status_t;

endpackage

// ----- rtl/sprite_animation_sequencer_top.sv -----
// Top level of the sprite animation sequencer.
// Each input transaction is a tick (tuser 0) that adds elapsed time, or an action request
// (tuser 1); every transaction yields exactly one result with the playing action, its
// frame and the reversing flag. A request, or a tick whose stored time does not yet cover
// the frame duration, goes to S_EMIT, which loads the result and raises m_tvalid once the
// output register is free. A covering tick passes S_DIV first: a restoring divider gives
// the step count and remainder, one of its 24 quotient bits per cycle, before the frame
// update and the S_EMIT load. One transaction is processed at a time, and the next is
// accepted while the last result still waits in the output register. Configuration
// writes are taken at any edge with cfg_we high and must be made while the block is idle.
module sprite_animation_sequencer_top #(
	parameter int NUM_ACTIONS = 4,
	parameter int TIME_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [63:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // elapsed_time[15:0], requested_action[17:16], zero fill
	input  logic [0:0]  s_tuser,  // opcode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // shown_action[1:0], shown_frame[9:2], reversing[10], zero fill
);

	sas_pkg::cmd_t    cmd;
	sas_pkg::status_t status;

	sas_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.status  (status),
		.cmd     (cmd)
	);

	sas_dp #(
		.NUM_ACTIONS(NUM_ACTIONS),
		.TIME_BITS  (TIME_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.status   (status),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- rtl/sas_div.sv -----
// Restoring divider for the accumulator, one quotient bit per cycle.
module sas_div #(
	parameter int TIME_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sas_pkg::ACC_BITS-1:0] dividend,
	input  logic [TIME_BITS-1:0]         divisor,
	output logic                         done,
	output logic [sas_pkg::ACC_BITS-1:0] quotient,
	output logic [sas_pkg::ACC_BITS-1:0] remainder
);

	localparam int AW = sas_pkg::ACC_BITS;
	localparam int CW = (TIME_BITS > AW + 1) ? TIME_BITS : AW + 1;
	localparam int NW = $clog2(AW);
	localparam logic [NW-1:0] LAST_STEP = NW'(AW - 1);

	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] cnt_q;
	logic [AW-1:0] rem_q;
	logic [AW-1:0] quo_q;
	logic [TIME_BITS-1:0] div_q;

	logic [AW:0]   shifted;
	logic [CW-1:0] shifted_w;
	logic [CW-1:0] div_w;
	logic [CW-1:0] diff_w;
	logic          fits;

	assign shifted   = {rem_q, quo_q[AW-1]};
	assign shifted_w = CW'(shifted);
	assign div_w     = CW'(div_q);
	assign diff_w    = shifted_w - div_w;
	assign fits      = shifted_w >= div_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			// The partial remainder never exceeds the dividend bits seen so far.
			rem_q <= fits ? diff_w[AW-1:0] : shifted[AW-1:0];
			quo_q <= {quo_q[AW-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/sas_dp.sv -----
// Datapath: configuration, animation state, frame update and result register.
module sas_dp #(
	parameter int NUM_ACTIONS = 4,
	parameter int TIME_BITS   = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_addr,
	input  logic [sas_pkg::CFG_BITS-1:0] cfg_wdata,
	input  logic [23:0]                  s_tdata,
	input  logic [0:0]                   s_tuser,
	input  sas_pkg::cmd_t                cmd,
	output sas_pkg::status_t             status,
	output logic [15:0]                  m_tdata
);

	localparam int AW = sas_pkg::ACC_BITS;
	localparam int FW = sas_pkg::FRAME_BITS;
	localparam int XW = sas_pkg::ACT_BITS;
	localparam int EW = sas_pkg::ELAPSED_BITS;
	localparam int CW = (TIME_BITS > AW) ? TIME_BITS : AW;

	logic [sas_pkg::CFG_BITS-1:0]     cfg_dur_q;
	logic [sas_pkg::CNT_REG_BITS-1:0] cfg_cnt_q;
	logic [sas_pkg::NUM_SLOTS-1:0]    cfg_loop_q;

	logic [XW-1:0] active_q;
	logic [XW-1:0] pending_q;
	logic          pending_valid_q;
	logic [FW-1:0] frame_q;
	logic [AW-1:0] acc_q;
	logic [EW-1:0] dt_q;

	logic [XW-1:0] out_action_q;
	logic [FW-1:0] out_frame_q;
	logic          out_rev_q;

	logic [TIME_BITS-1:0] dur_field [sas_pkg::NUM_SLOTS];
	logic [TIME_BITS-1:0] dur_raw;
	logic [TIME_BITS-1:0] dur_eff;
	logic [FW-1:0]        cnt_raw;
	logic [FW-1:0]        last_frame;
	logic                 act_loops;

	logic          opcode;
	logic [EW-1:0] elapsed;
	logic [XW-1:0] req;
	logic          req_valid;

	logic          div_start;
	logic          div_done;
	logic [AW-1:0] div_quo;
	logic [AW-1:0] div_rem;

	logic [AW:0]   tick_sum;
	logic [AW:0]   apply_sum;
	logic [AW:0]   up_sum;
	logic [FW-1:0] frame_next;
	logic [XW-1:0] active_next;
	logic          pend_clear;

	// Per-action duration fields; bits past the register read as zero.
	for (genvar a = 0; a < sas_pkg::NUM_SLOTS; a++) begin : g_dur
		for (genvar b = 0; b < TIME_BITS; b++) begin : g_bit
			if (a * TIME_BITS + b < sas_pkg::CFG_BITS) begin : g_in
				assign dur_field[a][b] = cfg_dur_q[a * TIME_BITS + b];
			end else begin : g_out
				assign dur_field[a][b] = 1'b0;
			end
		end
	end

	assign dur_raw    = dur_field[active_q];
	assign dur_eff    = (dur_raw == '0) ? TIME_BITS'(1) : dur_raw;
	assign cnt_raw    = cfg_cnt_q[{active_q, 3'b000} +: FW];
	assign last_frame = (cnt_raw == '0) ? '0 : cnt_raw - 1'b1;
	assign act_loops  = cfg_loop_q[active_q];

	assign opcode  = s_tuser[0];
	assign elapsed = s_tdata[EW-1:0];
	assign req     = s_tdata[EW +: XW];
	assign req_valid = (int'(req) < NUM_ACTIONS) && (req != active_q);

	assign status.div_needed = (opcode == sas_pkg::OP_TICK) && (CW'(acc_q) >= CW'(dur_eff));
	assign status.div_done   = div_done;
	assign div_start         = cmd.accept && status.div_needed;

	sas_div #(
		.TIME_BITS(TIME_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (dur_eff),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	assign tick_sum  = {1'b0, acc_q} + (AW + 1)'(elapsed);
	assign apply_sum = {1'b0, div_rem} + (AW + 1)'(dt_q);
	assign up_sum    = (AW + 1)'(frame_q) + {1'b0, div_quo};

	// Frame step by the quotient after division; backwards while a change waits.
	always_comb begin
		frame_next  = frame_q;
		active_next = active_q;
		pend_clear  = 1'b0;
		if (act_loops) begin
			if (frame_q >= last_frame) begin
				frame_next = '0;
			end else if (up_sum > (AW + 1)'(sas_pkg::FRAME_MAX)) begin
				frame_next = sas_pkg::FRAME_MAX;
			end else begin
				frame_next = up_sum[FW-1:0];
			end
		end else if (pending_valid_q) begin
			if (frame_q != '0) begin
				if (div_quo >= AW'(frame_q)) begin
					frame_next = '0;
				end else begin
					frame_next = frame_q - div_quo[FW-1:0];
				end
			end else begin
				active_next = pending_q;
				pend_clear  = 1'b1;
			end
		end else if (frame_q < last_frame) begin
			if (up_sum > (AW + 1)'(last_frame)) begin
				frame_next = last_frame;
			end else begin
				frame_next = up_sum[FW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_dur_q  <= '0;
			cfg_cnt_q  <= 32'h0101_0101;
			cfg_loop_q <= '1;
		end else if (cfg_we) begin
			case (cfg_addr)
				sas_pkg::REG_DURATIONS:    cfg_dur_q  <= cfg_wdata;
				sas_pkg::REG_FRAME_COUNTS: cfg_cnt_q  <= cfg_wdata[sas_pkg::CNT_REG_BITS-1:0];
				sas_pkg::REG_LOOPING_MASK: cfg_loop_q <= cfg_wdata[sas_pkg::NUM_SLOTS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q        <= '0;
			pending_q       <= '0;
			pending_valid_q <= 1'b0;
			frame_q         <= '0;
			acc_q           <= '0;
		end else if (cmd.accept) begin
			if (opcode == sas_pkg::OP_SET) begin
				if (req_valid) begin
					if (act_loops) begin
						active_q <= req;
						frame_q  <= '0;
					end else begin
						pending_q       <= req;
						pending_valid_q <= 1'b1;
					end
				end
			end else if (!status.div_needed) begin
				acc_q <= tick_sum[AW] ? sas_pkg::ACC_MAX : tick_sum[AW-1:0];
			end
		end else if (cmd.apply) begin
			frame_q  <= frame_next;
			active_q <= active_next;
			if (pend_clear) begin
				pending_valid_q <= 1'b0;
			end
			acc_q <= apply_sum[AW] ? sas_pkg::ACC_MAX : apply_sum[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dt_q <= elapsed;
		end
		if (cmd.load_out) begin
			out_action_q <= active_q;
			out_frame_q  <= frame_q;
			out_rev_q    <= pending_valid_q && !act_loops;
		end
	end

	assign m_tdata = {5'b0, out_rev_q, out_frame_q, out_action_q};

endmodule

// ----- rtl/sas_ctrl.sv -----
// Controller: input and output handshakes and the sequencing of one item.
module sas_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  sas_pkg::status_t status,
	output sas_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_next   = state_q;
		cmd.accept   = 1'b0;
		cmd.apply    = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_next = status.div_needed ? S_DIV : S_EMIT;
				end
			end
			S_DIV: begin
				if (status.div_done) begin
					cmd.apply  = 1'b1;
					state_next = S_EMIT;
				end
			end
			S_EMIT: begin
				// The result waits here until the output register is free.
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_next   = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

// ----- rtl/sas_chk.sv -----
// Port-level checker of the sprite animation sequencer and its bind.
module sas_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// Only one transaction is in work at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted again while a transaction is in work");

	// A new result is loaded only while the input side is closed.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without a transaction in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind sprite_animation_sequencer_top sas_chk u_chk (.*);
